// File: hw/rtl/smas_pkg.sv
// ----------------------------------------------------------------------------
// smas_pkg
// Shared types and constants of the sensor moving-average statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package smas_pkg;

  localparam int unsigned WinLen    = 8;
  localparam int unsigned SlotW     = (WinLen > 1) ? $clog2(WinLen) : 1;
  localparam int unsigned CodeW     = 10;
  localparam int unsigned OffsetW   = 11;
  localparam int unsigned ModeW     = 3;
  localparam int unsigned TotalW    = 32;
  localparam int unsigned SumW      = CodeW + $clog2(WinLen);
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 120;
  localparam logic [CodeW-1:0]  MaxCode  = '1;
  localparam logic [TotalW-1:0] TotalMax = '1;

  typedef enum logic [ModeW-1:0] {
    MODE_SAMPLE       = 3'd0,
    MODE_TICK         = 3'd1,
    MODE_DAY_RST      = 3'd2,
    MODE_PERIOD_RST   = 3'd3,
    MODE_PER_TOT_RST  = 3'd4
  } mode_e;

  typedef struct packed {
    logic [TotalW-1:0] period_total;
    logic [TotalW-1:0] day_total;
    logic [CodeW-1:0]  period_min;
    logic [CodeW-1:0]  period_max;
    logic [CodeW-1:0]  day_min;
    logic [CodeW-1:0]  day_max;
    logic [CodeW-1:0]  average;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/sensor_moving_average_stats.sv
// ----------------------------------------------------------------------------
// sensor_moving_average_stats
// Boxcar moving average over a sample ring with day and period min/max/totals.
// ----------------------------------------------------------------------------
// One transfer in, one result out, one item per cycle sustained while the
// output is not stalled. An item is accepted at the input and its window
// entry is read from the ring memory into a register; when the item moves
// on, the sum, average, min/max and totals are updated, the entry is written
// back and the result is loaded into the output register. The first sample
// after reset stands for the whole window through a fill value until the
// ring has wrapped once, so no clearing pass is needed. The input is ready
// whenever the output register is empty or being taken.
`default_nettype none

module sensor_moving_average_stats
  import smas_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire  [OffsetW-1:0]    cfg_wdata_i,   // sample_offset, signed
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire  [InDataW-1:0]    s_axis_tdata,  // [9:0] raw_sample
  input  wire  [ModeW-1:0]      s_axis_tuser,  // [2:0] mode
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  output logic [OutDataW-1:0]   m_axis_tdata   // average, day_max, day_min,
                                               // period_max, period_min,
                                               // day_total, period_total
);

  logic                    advance;
  logic                    in_xfer;
  logic [OffsetW-1:0]      offset_q;
  logic signed [CodeW+1:0] offs_sum;
  logic [CodeW-1:0]        samp_v;
  mode_e                   in_mode;

  logic                    first_pend_q;
  logic                    wrapped_q;
  logic [SlotW-1:0]        slot_q;
  logic [CodeW-1:0]        fill_q;

  logic [CodeW-1:0]        win_mem_q [WinLen];
  logic [CodeW-1:0]        rd_data_q;

  logic                    s1_valid_q;
  mode_e                   s1_mode_q;
  logic [CodeW-1:0]        s1_samp_q;
  logic [SlotW-1:0]        s1_slot_q;
  logic                    s1_first_q;
  logic                    s1_mem_q;
  logic                    s1_fire;

  logic [SumW-1:0]         sum_q, sum_d;
  logic [CodeW-1:0]        avg_q, avg_d;
  logic [CodeW-1:0]        dmax_q, dmax_d, dmin_q, dmin_d;
  logic [CodeW-1:0]        pmax_q, pmax_d, pmin_q, pmin_d;
  logic [TotalW-1:0]       dtot_q, dtot_d, ptot_q, ptot_d;
  logic [CodeW-1:0]        old_v;
  logic [SumW-1:0]         sum_upd;
  logic [SumW:0]           sum_rnd;
  logic [CodeW-1:0]        avg_upd;
  logic [TotalW:0]         dtot_add, ptot_add;

  logic                    out_valid_q;
  result_t                 out_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_xfer       = s_axis_tvalid && advance;
  assign s1_fire       = s1_valid_q && advance;
  assign in_mode       = mode_e'(s_axis_tuser);

  // offset and clamp
  assign offs_sum = $signed({2'b00, s_axis_tdata[CodeW-1:0]})
                  + $signed({offset_q[OffsetW-1], offset_q});
  always_comb begin
    if (offs_sum < 0) begin
      samp_v = '0;
    end else if (offs_sum > $signed({2'b00, MaxCode})) begin
      samp_v = MaxCode;
    end else begin
      samp_v = offs_sum[CodeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  // ring control at acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pend_q <= 1'b1;
      wrapped_q    <= 1'b0;
      slot_q       <= '0;
    end else if (in_xfer && in_mode == MODE_SAMPLE) begin
      if (first_pend_q) begin
        first_pend_q <= 1'b0;
      end else begin
        if (slot_q == SlotW'(WinLen - 1)) begin
          slot_q    <= '0;
          wrapped_q <= 1'b1;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && in_mode == MODE_SAMPLE && first_pend_q) begin
      fill_q <= samp_v;
    end
  end

  // ring memory: read at acceptance, write back when the item completes
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_data_q <= win_mem_q[slot_q];
    end
    if (s1_fire && s1_mode_q == MODE_SAMPLE && !s1_first_q) begin
      win_mem_q[s1_slot_q] <= s1_samp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_mode_q  <= in_mode;
      s1_samp_q  <= samp_v;
      s1_slot_q  <= slot_q;
      s1_first_q <= first_pend_q;
      s1_mem_q   <= wrapped_q;
    end
  end

  // update
  assign old_v    = s1_mem_q ? rd_data_q : fill_q;
  assign sum_upd  = sum_q - SumW'(old_v) + SumW'(s1_samp_q);
  assign sum_rnd  = {1'b0, sum_upd} + (SumW+1)'(WinLen / 2);
  assign avg_upd  = CodeW'(sum_rnd / WinLen);
  assign dtot_add = {1'b0, dtot_q} + (TotalW+1)'(avg_q);
  assign ptot_add = {1'b0, ptot_q} + (TotalW+1)'(avg_q);

  always_comb begin
    sum_d  = sum_q;
    avg_d  = avg_q;
    dmax_d = dmax_q;
    dmin_d = dmin_q;
    pmax_d = pmax_q;
    pmin_d = pmin_q;
    dtot_d = dtot_q;
    ptot_d = ptot_q;
    unique case (s1_mode_q)
      MODE_SAMPLE: begin
        if (s1_first_q) begin
          sum_d = SumW'(s1_samp_q) * SumW'(WinLen);
        end else begin
          sum_d = sum_upd;
          avg_d = avg_upd;
          if (dmax_q < avg_upd) begin
            dmax_d = avg_upd;
          end else if (dmin_q > avg_upd) begin
            dmin_d = avg_upd;
          end
          if (pmax_q < avg_upd) begin
            pmax_d = avg_upd;
          end else if (pmin_q > avg_upd) begin
            pmin_d = avg_upd;
          end
        end
      end
      MODE_TICK: begin
        dtot_d = dtot_add[TotalW] ? TotalMax : dtot_add[TotalW-1:0];
        ptot_d = ptot_add[TotalW] ? TotalMax : ptot_add[TotalW-1:0];
      end
      MODE_DAY_RST: begin
        dmax_d = avg_q;
        dmin_d = avg_q;
        dtot_d = '0;
      end
      MODE_PERIOD_RST: begin
        pmax_d = avg_q;
        pmin_d = avg_q;
        ptot_d = '0;
      end
      MODE_PER_TOT_RST: begin
        ptot_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      avg_q  <= '0;
      dmax_q <= '0;
      dmin_q <= MaxCode;
      pmax_q <= '0;
      pmin_q <= MaxCode;
      dtot_q <= '0;
      ptot_q <= '0;
    end else if (s1_fire) begin
      sum_q  <= sum_d;
      avg_q  <= avg_d;
      dmax_q <= dmax_d;
      dmin_q <= dmin_d;
      pmax_q <= pmax_d;
      pmin_q <= pmin_d;
      dtot_q <= dtot_d;
      ptot_q <= ptot_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q.average      <= avg_d;
      out_q.day_max      <= dmax_d;
      out_q.day_min      <= dmin_d;
      out_q.period_max   <= pmax_d;
      out_q.period_min   <= pmin_d;
      out_q.day_total    <= dtot_d;
      out_q.period_total <= ptot_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - $bits(result_t))'(0), out_q};

endmodule

`default_nettype wire

// File: hw/rtl/smas_checker.sv
// ----------------------------------------------------------------------------
// smas_checker
// Port-level checks of the sensor moving-average statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

module smas_checker
  import smas_pkg::*;
(
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  s_axis_tvalid,
  input wire                  s_axis_tready,
  input wire                  m_axis_tvalid,
  input wire                  m_axis_tready,
  input wire [OutDataW-1:0]   m_axis_tdata
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // accepted item reaches the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
    else $error("accepted transfer produced no result");

  // input never blocked while the output is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // padding bits stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:$bits(result_t)] == '0)
    else $error("result padding not zero");

endmodule

bind sensor_moving_average_stats smas_checker u_smas_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sensor_moving_average_stats.
// A short table of hand-picked items opens the run. Some rows carry their
// expected statistics typed in, and the rest are predicted. After it come
// random items in six segments, each with its own sample offset; pairs of
// segments share an idle regime. Every result is compared field by field
// with an in-bench model of the offset clamp, the eight-entry boxcar average,
// the day and period min/max tracking and the saturating tick totals.
// ----------------------------------------------------------------------------
module tb;
  import smas_pkg::*;

  localparam logic [ModeW-1:0] ModeSpare5 = 3'd5;
  localparam logic [ModeW-1:0] ModeSpare6 = 3'd6;
  localparam logic [ModeW-1:0] ModeSpare7 = 3'd7;

  typedef struct {
    logic [ModeW-1:0] mode;
    logic [CodeW-1:0] raw;
    bit               typed;
    int unsigned      avg, dmax, dmin, pmax, pmin, dtot, ptot;
  } step_t;

  // fields after mode/raw/typed: average, day max, day min, period max,
  // period min, day total, period total
  step_t directed_steps [21] = '{
    '{MODE_TICK,        10'd0,    1'b1, 0,    0,    1023, 0,    1023, 0,    0},
    '{MODE_SAMPLE,      10'd1023, 1'b1, 0,    0,    1023, 0,    1023, 0,    0},
    '{MODE_SAMPLE,      10'd1023, 1'b1, 1023, 1023, 1023, 1023, 1023, 0,    0},
    '{MODE_TICK,        10'd0,    1'b1, 1023, 1023, 1023, 1023, 1023, 1023, 1023},
    '{MODE_PER_TOT_RST, 10'd0,    1'b1, 1023, 1023, 1023, 1023, 1023, 1023, 0},
    '{ModeSpare5,       10'd1023, 1'b1, 1023, 1023, 1023, 1023, 1023, 1023, 0},
    '{ModeSpare6,       10'd1023, 1'b1, 1023, 1023, 1023, 1023, 1023, 1023, 0},
    '{ModeSpare7,       10'd1023, 1'b1, 1023, 1023, 1023, 1023, 1023, 1023, 0},
    '{MODE_SAMPLE,      10'd0,    1'b0, 0, 0, 0, 0, 0, 0, 0},
    '{MODE_SAMPLE,      10'd0,    1'b0, 0, 0, 0, 0, 0, 0, 0},
    '{MODE_SAMPLE,      10'd0,    1'b0, 0, 0, 0, 0, 0, 0, 0},
    '{MODE_SAMPLE,      10'd0,    1'b0, 0, 0, 0, 0, 0, 0, 0},
    '{MODE_SAMPLE,      10'd0,    1'b0, 0, 0, 0, 0, 0, 0, 0},
    '{MODE_SAMPLE,      10'd0,    1'b0, 0, 0, 0, 0, 0, 0, 0},
    '{MODE_SAMPLE,      10'd0,    1'b0, 0, 0, 0, 0, 0, 0, 0},
    '{MODE_SAMPLE,      10'd0,    1'b0, 0, 0, 0, 0, 0, 0, 0},
    '{MODE_DAY_RST,     10'd0,    1'b0, 0, 0, 0, 0, 0, 0, 0},
    '{MODE_PERIOD_RST,  10'd0,    1'b0, 0, 0, 0, 0, 0, 0, 0},
    '{MODE_SAMPLE,      10'h2AA,  1'b0, 0, 0, 0, 0, 0, 0, 0},
    '{MODE_SAMPLE,      10'h155,  1'b0, 0, 0, 0, 0, 0, 0, 0},
    '{MODE_TICK,        10'd0,    1'b0, 0, 0, 0, 0, 0, 0, 0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [OffsetW-1:0]   cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic [ModeW-1:0]     s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;

  sensor_moving_average_stats dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // model state
  logic signed [OffsetW-1:0] offset_q = '0;
  logic [CodeW-1:0]  win_ring [WinLen];
  int                win_sum = 0;
  int                wr_slot = 0;
  bit                fill_pending = 1'b1;
  logic [CodeW-1:0]  avg_q = '0;
  logic [CodeW-1:0]  day_hi = '0;
  logic [CodeW-1:0]  day_lo = MaxCode;
  logic [CodeW-1:0]  per_hi = '0;
  logic [CodeW-1:0]  per_lo = MaxCode;
  logic [TotalW-1:0] day_acc = '0;
  logic [TotalW-1:0] per_acc = '0;

  result_t expected_results [$];
  result_t want_res, got_res;
  int      failures = 0;
  int      tx_idle_pct = 0;
  int      rx_stall_pct = 0;
  int      raw_level = 512;

  function automatic logic [TotalW-1:0] add_sat(logic [TotalW-1:0] acc,
                                                logic [CodeW-1:0] inc);
    logic [TotalW:0] wide;
    wide = {1'b0, acc} + inc;
    return wide[TotalW] ? TotalMax : wide[TotalW-1:0];
  endfunction

  function automatic result_t stats_after(logic [ModeW-1:0] mode,
                                          logic [CodeW-1:0] raw);
    int      level;
    result_t r;
    case (mode)
      MODE_SAMPLE: begin
        level = int'(raw) + int'(offset_q);
        if (level < 0) level = 0;
        if (level > int'(MaxCode)) level = int'(MaxCode);
        if (fill_pending) begin
          fill_pending = 1'b0;
          wr_slot = 0;
          foreach (win_ring[i]) win_ring[i] = CodeW'(level);
          win_sum = level * WinLen;
        end else begin
          win_sum = win_sum - int'(win_ring[wr_slot]) + level;
          win_ring[wr_slot] = CodeW'(level);
          wr_slot = (wr_slot + 1) % WinLen;
          avg_q = CodeW'((win_sum + WinLen / 2) / WinLen);
          if (day_hi < avg_q) day_hi = avg_q;
          else if (day_lo > avg_q) day_lo = avg_q;
          if (per_hi < avg_q) per_hi = avg_q;
          else if (per_lo > avg_q) per_lo = avg_q;
        end
      end
      MODE_TICK: begin
        day_acc = add_sat(day_acc, avg_q);
        per_acc = add_sat(per_acc, avg_q);
      end
      MODE_DAY_RST: begin
        day_hi = avg_q;
        day_lo = avg_q;
        day_acc = '0;
      end
      MODE_PERIOD_RST: begin
        per_hi = avg_q;
        per_lo = avg_q;
        per_acc = '0;
      end
      MODE_PER_TOT_RST: per_acc = '0;
      default: ;
    endcase
    r.average      = avg_q;
    r.day_max      = day_hi;
    r.day_min      = day_lo;
    r.period_max   = per_hi;
    r.period_min   = per_lo;
    r.day_total    = day_acc;
    r.period_total = per_acc;
    return r;
  endfunction

  task automatic send_item(logic [ModeW-1:0] mode, logic [CodeW-1:0] raw,
                           bit typed, result_t typed_res);
    result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    predicted = stats_after(mode, raw);
    expected_results.push_back(typed ? typed_res : predicted);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= InDataW'(raw);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drain, then write the offset while the block is idle
  task automatic write_offset(int value);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= OffsetW'(value);
    offset_q     = OffsetW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int count);
    int               pick;
    int               lvl;
    logic [CodeW-1:0] raw;
    logic [ModeW-1:0] mode;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      raw = CodeW'($urandom_range(0, int'(MaxCode)));
      if (pick < 8) begin
        raw = '0;
      end else if (pick < 16) begin
        raw = MaxCode;
      end else if (pick < 50) begin
        lvl = raw_level + int'($urandom_range(0, 32)) - 16;
        if (lvl < 0) lvl = 0;
        if (lvl > int'(MaxCode)) lvl = int'(MaxCode);
        raw = CodeW'(lvl);
      end
      if ($urandom_range(0, 39) == 0) raw_level = $urandom_range(0, int'(MaxCode));
      pick = $urandom_range(0, 99);
      if (pick < 68) mode = MODE_SAMPLE;
      else if (pick < 83) mode = MODE_TICK;
      else if (pick < 88) mode = MODE_DAY_RST;
      else if (pick < 93) mode = MODE_PERIOD_RST;
      else if (pick < 96) mode = MODE_PER_TOT_RST;
      else mode = ModeW'(ModeSpare5 + $urandom_range(0, ModeSpare7 - ModeSpare5));
      send_item(mode, raw, 1'b0, '0);
    end
  endtask

  task automatic check_field(string name, logic [TotalW-1:0] want_v,
                             logic [TotalW-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, m_axis_tdata);
        failures++;
      end else begin
        want_res = expected_results.pop_front();
        got_res  = m_axis_tdata[$bits(result_t)-1:0];
        check_field("average",      want_res.average,      got_res.average);
        check_field("day_max",      want_res.day_max,      got_res.day_max);
        check_field("day_min",      want_res.day_min,      got_res.day_min);
        check_field("period_max",   want_res.period_max,   got_res.period_max);
        check_field("period_min",   want_res.period_min,   got_res.period_min);
        check_field("day_total",    want_res.day_total,    got_res.day_total);
        check_field("period_total", want_res.period_total, got_res.period_total);
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  initial begin
    result_t hand;
    int      off;
    foreach (win_ring[i]) win_ring[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct  = 20;
    rx_stall_pct = 67;
    foreach (directed_steps[i]) begin
      hand.average      = CodeW'(directed_steps[i].avg);
      hand.day_max      = CodeW'(directed_steps[i].dmax);
      hand.day_min      = CodeW'(directed_steps[i].dmin);
      hand.period_max   = CodeW'(directed_steps[i].pmax);
      hand.period_min   = CodeW'(directed_steps[i].pmin);
      hand.day_total    = TotalW'(directed_steps[i].dtot);
      hand.period_total = TotalW'(directed_steps[i].ptot);
      send_item(directed_steps[i].mode, directed_steps[i].raw,
                directed_steps[i].typed, hand);
    end
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: off = -1023;
        1: off = 1023;
        3: off = int'($urandom_range(0, 128)) - 64;
        4: off = 0;
        default: off = int'($urandom_range(0, 2046)) - 1023;
      endcase
      if (seg < 2) begin
        tx_idle_pct  = 20;
        rx_stall_pct = 67;
      end else if (seg < 4) begin
        tx_idle_pct  = 67;
        rx_stall_pct = 20;
      end else begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      write_offset(off);
      run_random(300);
    end
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (failures == 0) begin
      $display("sensor_moving_average_stats verification clean");
    end else begin
      $display("sensor_moving_average_stats verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("sensor_moving_average_stats verification failed");
    $finish;
  end

endmodule
